### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU slot replacement package
// Shared types, field widths and codes for the LFU slot replacement core.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ID_W          = 8;
    localparam int VOTE_W        = 10;
    localparam int CFG_W         = 6;
    localparam int KIND_W        = 2;
    localparam int MAX_SLOTS_DEF = 32;
    localparam int STAMP_W_DEF   = 32;

    localparam logic [CFG_W-1:0]  FRAMES_RESET = CFG_W'(20);
    localparam logic [VOTE_W-1:0] VOTE_MAX     = {VOTE_W{1'b1}};

    typedef enum logic {
        OP_RECOMMEND = 1'b0,
        OP_LIST      = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECOMMEND = 2'd0,
        KIND_ENTRY     = 2'd1,
        KIND_EMPTY     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_LIST_EMIT
    } state_t;

    typedef struct packed {
        op_t             opcode;
        logic [ID_W-1:0] candidate_id;
    } cmd_t;

    typedef struct packed {
        kind_t             result_kind;
        logic              hit;
        logic              evicted_valid;
        logic [ID_W-1:0]   evicted_id;
        logic [ID_W-1:0]   entry_id;
        logic [VOTE_W-1:0] entry_votes;
        logic              last;
    } result_t;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic data_vld;
        logic mode_list;
        logic have_prev;
    } scan_ctl_t;

    // Status flags reported by the scan unit.
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic vic_found;
        logic min_found;
    } scan_flags_t;

endpackage

### hw/rtl/lfu_slot_mem.sv
// ----------------------------------------------------------------------------
// LFU slot memory
// Slot storage for id, votes and stamp with a registered read port and
// per-slot valid bits cleared by reset.
// ----------------------------------------------------------------------------
module lfu_slot_mem #(
    parameter int MAX_SLOTS = lfu_pkg::MAX_SLOTS_DEF,
    parameter int STAMP_W   = lfu_pkg::STAMP_W_DEF,
    parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic                      rd_valid,
    output logic [lfu_pkg::ID_W-1:0]  rd_id,
    output logic [lfu_pkg::VOTE_W-1:0] rd_votes,
    output logic [STAMP_W-1:0]        rd_stamp,
    input  logic                      we,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [lfu_pkg::ID_W-1:0]  wr_id,
    input  logic [lfu_pkg::VOTE_W-1:0] wr_votes,
    input  logic [STAMP_W-1:0]        wr_stamp
);
    import lfu_pkg::*;

    logic [ID_W-1:0]    id_mem    [MAX_SLOTS];
    logic [VOTE_W-1:0]  votes_mem [MAX_SLOTS];
    logic [STAMP_W-1:0] stamp_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            id_mem[wr_addr]    <= wr_id;
            votes_mem[wr_addr] <= wr_votes;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_id    <= id_mem[rd_addr];
            rd_votes <= votes_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

### hw/rtl/lfu_scan_unit.sv
// ----------------------------------------------------------------------------
// LFU scan unit
// Shared compare unit that looks at one slot a cycle and keeps the running
// match, free slot, eviction victim and smallest listable id.
// ----------------------------------------------------------------------------
module lfu_scan_unit #(
    parameter int MAX_SLOTS = lfu_pkg::MAX_SLOTS_DEF,
    parameter int STAMP_W   = lfu_pkg::STAMP_W_DEF,
    parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfu_pkg::scan_ctl_t         ctl,
    input  logic [IDX_W-1:0]           slot_idx,
    input  logic                       slot_valid,
    input  logic [lfu_pkg::ID_W-1:0]   slot_id,
    input  logic [lfu_pkg::VOTE_W-1:0] slot_votes,
    input  logic [STAMP_W-1:0]         slot_stamp,
    input  logic [lfu_pkg::ID_W-1:0]   key_id,
    input  logic [lfu_pkg::ID_W-1:0]   prev_id,
    output lfu_pkg::scan_flags_t       flags,
    output logic [CNT_W-1:0]           count,
    output logic [IDX_W-1:0]           match_idx,
    output logic [lfu_pkg::VOTE_W-1:0] match_votes,
    output logic [STAMP_W-1:0]         match_stamp,
    output logic [IDX_W-1:0]           free_idx,
    output logic [IDX_W-1:0]           vic_idx,
    output logic [lfu_pkg::ID_W-1:0]   vic_id,
    output logic [lfu_pkg::ID_W-1:0]   min_id,
    output logic [lfu_pkg::VOTE_W-1:0] min_votes
);
    import lfu_pkg::*;

    scan_flags_t        flags_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [VOTE_W-1:0]  match_votes_reg;
    logic [STAMP_W-1:0] match_stamp_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [VOTE_W-1:0]  vic_votes_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    logic [ID_W-1:0]    vic_id_reg;
    logic [ID_W-1:0]    min_id_reg;
    logic [VOTE_W-1:0]  min_votes_reg;

    logic take_match;
    logic take_free;
    logic take_vic;
    logic take_min;

    always_comb
    begin
        take_match = 1'b0;
        take_free  = 1'b0;
        take_vic   = 1'b0;
        take_min   = 1'b0;
        if (ctl.data_vld)
        begin
            if (ctl.mode_list)
            begin
                // Smallest id above the one listed last.
                take_min = slot_valid
                           && (!ctl.have_prev || slot_id > prev_id)
                           && (!flags_reg.min_found || slot_id < min_id_reg);
            end
            else if (slot_valid)
            begin
                take_match = (slot_id == key_id);
                // Fewest votes first, then the oldest stamp, then the smaller id.
                take_vic = !flags_reg.vic_found
                           || (slot_votes < vic_votes_reg)
                           || (slot_votes == vic_votes_reg && slot_stamp < vic_stamp_reg)
                           || (slot_votes == vic_votes_reg && slot_stamp == vic_stamp_reg
                               && slot_id < vic_id_reg);
            end
            else
            begin
                take_free = !flags_reg.free_found;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            flags_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.data_vld && slot_valid)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (take_match)
            begin
                flags_reg.match_found <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
            if (take_vic)
            begin
                flags_reg.vic_found <= 1'b1;
            end
            if (take_min)
            begin
                flags_reg.min_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            match_idx_reg   <= slot_idx;
            match_votes_reg <= slot_votes;
            match_stamp_reg <= slot_stamp;
        end
        if (take_free)
        begin
            free_idx_reg <= slot_idx;
        end
        if (take_vic)
        begin
            vic_idx_reg   <= slot_idx;
            vic_votes_reg <= slot_votes;
            vic_stamp_reg <= slot_stamp;
            vic_id_reg    <= slot_id;
        end
        if (take_min)
        begin
            min_id_reg    <= slot_id;
            min_votes_reg <= slot_votes;
        end
    end

    assign flags       = flags_reg;
    assign count       = count_reg;
    assign match_idx   = match_idx_reg;
    assign match_votes = match_votes_reg;
    assign match_stamp = match_stamp_reg;
    assign free_idx    = free_idx_reg;
    assign vic_idx     = vic_idx_reg;
    assign vic_id      = vic_id_reg;
    assign min_id      = min_id_reg;
    assign min_votes   = min_votes_reg;

endmodule

### hw/rtl/lfu_slot_replacement_oldest_tiebreak_core.sv
// ----------------------------------------------------------------------------
// LFU slot replacement core with oldest-first tiebreak
// Vote-counting slot store: recommends add votes or insert ids with
// least-votes, oldest-stamp eviction; list requests report ids ascending.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Word
//  -------   ---------------------   ------------------------------------
//  command   start & !busy           cmd      (opcode, candidate_id)
//  result    done (one cycle)        result   (kind, hit, eviction, entry)
//  config    cfg_we                  cfg_data (frames_in_use)
//
// A recommend scans every slot, reading one slot per cycle through the single
// read port of the slot memory, whose read data is registered; the update
// state then writes the slot and registers the result word for the ports.
// A list takes one such scan per resident id (one id is found per pass), or
// a single scan when the store is empty; each pass ends with one result
// word.
// busy stays high from acceptance until the last word is on the result ports,
// and a new command may be accepted in that very cycle. Reset empties all
// slots at once through the valid flags and clears the sequence counter.
// The receiver cannot stall: each result word is present for one cycle only.
//
module lfu_slot_replacement_oldest_tiebreak_core #(
    parameter int MAX_SLOTS = lfu_pkg::MAX_SLOTS_DEF,
    parameter int STAMP_W   = lfu_pkg::STAMP_W_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lfu_pkg::cmd_t             cmd,
    output logic                      done,
    output lfu_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] cfg_data
);
    import lfu_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

    // Sequencer state.
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]   pipe_idx_reg, pipe_idx_next;
    logic [STAMP_W-1:0] seq_reg, seq_next;
    logic [CFG_W-1:0]   frames_reg;
    logic [ID_W-1:0]    prev_id_reg, prev_id_next;
    logic               have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    // Memory and scan unit connections.
    logic               rd_en;
    logic               rd_valid;
    logic [ID_W-1:0]    rd_id;
    logic [VOTE_W-1:0]  rd_votes;
    logic [STAMP_W-1:0] rd_stamp;
    logic               we;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_W-1:0]    wr_id;
    logic [VOTE_W-1:0]  wr_votes;
    logic [STAMP_W-1:0] wr_stamp;

    scan_ctl_t          ctl;
    scan_flags_t        flags;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   match_idx;
    logic [VOTE_W-1:0]  match_votes;
    logic [STAMP_W-1:0] match_stamp;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   vic_idx;
    logic [ID_W-1:0]    vic_id;
    logic [ID_W-1:0]    min_id;
    logic [VOTE_W-1:0]  min_votes;

    // Update helpers.
    logic [CW-1:0]      limit;
    logic               evict;
    logic [VOTE_W-1:0]  votes_inc;
    logic               list_last;

    lfu_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .STAMP_W   (STAMP_W),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .rd_valid (rd_valid),
        .rd_id    (rd_id),
        .rd_votes (rd_votes),
        .rd_stamp (rd_stamp),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_id    (wr_id),
        .wr_votes (wr_votes),
        .wr_stamp (wr_stamp)
    );

    lfu_scan_unit #(
        .MAX_SLOTS (MAX_SLOTS),
        .STAMP_W   (STAMP_W),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .slot_idx    (pipe_idx_reg),
        .slot_valid  (rd_valid),
        .slot_id     (rd_id),
        .slot_votes  (rd_votes),
        .slot_stamp  (rd_stamp),
        .key_id      (key_reg),
        .prev_id     (prev_id_reg),
        .flags       (flags),
        .count       (count),
        .match_idx   (match_idx),
        .match_votes (match_votes),
        .match_stamp (match_stamp),
        .free_idx    (free_idx),
        .vic_idx     (vic_idx),
        .vic_id      (vic_id),
        .min_id      (min_id),
        .min_votes   (min_votes)
    );

    // The configured limit is pulled into the range one to MAX_SLOTS.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (CW'(frames_reg) > CW'(MAX_SLOTS))
        begin
            limit = CW'(MAX_SLOTS);
        end
        else
        begin
            limit = CW'(frames_reg);
        end
    end

    assign evict     = (CW'(count) >= limit) && flags.vic_found;
    assign votes_inc = (match_votes == VOTE_MAX) ? match_votes : match_votes + VOTE_W'(1);
    assign list_last = ((emitted_reg + CNT_W'(1)) == count);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = pipe_idx_reg;
        seq_next       = seq_reg;
        prev_id_next   = prev_id_reg;
        have_prev_next = have_prev_reg;
        emitted_next   = emitted_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        rd_en          = 1'b0;
        we             = 1'b0;
        wr_addr        = match_idx;
        wr_id          = key_reg;
        wr_votes       = votes_inc;
        wr_stamp       = match_stamp;

        ctl.clear      = 1'b0;
        ctl.data_vld   = pipe_vld_reg;
        ctl.mode_list  = (op_reg == OP_LIST);
        ctl.have_prev  = have_prev_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = cmd.opcode;
                    key_next       = cmd.candidate_id;
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    emitted_next   = '0;
                    ctl.clear      = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one slot ahead of the compare.
                rd_en = (idx_reg < CNT_W'(MAX_SLOTS));
                if (rd_en)
                begin
                    idx_next      = idx_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg[IDX_W-1:0];
                end
                if (pipe_vld_reg && pipe_idx_reg == LAST_IDX)
                begin
                    state_next = (op_reg == OP_LIST) ? ST_LIST_EMIT : ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                we                        = 1'b1;
                result_next.result_kind   = KIND_RECOMMEND;
                result_next.hit           = flags.match_found;
                result_next.entry_id      = key_reg;
                result_next.last          = 1'b1;
                result_next.evicted_valid = 1'b0;
                result_next.evicted_id    = '0;
                if (flags.match_found)
                begin
                    result_next.entry_votes = votes_inc;
                end
                else
                begin
                    // A new id goes to the victim when the store is at its
                    // limit, otherwise to the lowest free slot.
                    if (evict)
                    begin
                        wr_addr                   = vic_idx;
                        result_next.evicted_valid = 1'b1;
                        result_next.evicted_id    = vic_id;
                    end
                    else if (flags.free_found)
                    begin
                        wr_addr = free_idx;
                    end
                    else
                    begin
                        wr_addr = vic_idx;
                    end
                    wr_votes                = VOTE_W'(1);
                    wr_stamp                = seq_reg;
                    result_next.entry_votes = VOTE_W'(1);
                end
                seq_next   = seq_reg + STAMP_W'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_LIST_EMIT:
            begin
                done_next                 = 1'b1;
                result_next.hit           = 1'b0;
                result_next.evicted_valid = 1'b0;
                result_next.evicted_id    = '0;
                if (count == '0)
                begin
                    result_next.result_kind = KIND_EMPTY;
                    result_next.entry_id    = '0;
                    result_next.entry_votes = '0;
                    result_next.last        = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    result_next.result_kind = KIND_ENTRY;
                    result_next.entry_id    = min_id;
                    result_next.entry_votes = min_votes;
                    result_next.last        = list_last;
                    prev_id_next            = min_id;
                    have_prev_next          = 1'b1;
                    emitted_next            = emitted_reg + CNT_W'(1);
                    if (list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Start another pass for the next larger id.
                        idx_next   = '0;
                        ctl.clear  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pipe_vld_reg  <= 1'b0;
            seq_reg       <= '0;
            frames_reg    <= FRAMES_RESET;
            have_prev_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pipe_vld_reg  <= pipe_vld_next;
            seq_reg       <= seq_next;
            have_prev_reg <= have_prev_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                frames_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        prev_id_reg  <= prev_id_next;
        emitted_reg  <= emitted_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
